// ===== rtl/rcfr_pkg.sv =====
// Package for the RC channel frame receiver: frame constants, payload type,
// queue status struct and the byte-wide CRC-8 (poly 0xD5) step.
// No dependencies.
`default_nettype none

package rcfr_pkg;

    localparam int unsigned FRAME_BYTES   = 26;
    localparam int unsigned PAYLOAD_BYTES = 22;
    localparam int unsigned HDR_BYTES     = 3;
    localparam int unsigned CRC_BYTES     = FRAME_BYTES - 1;
    localparam int unsigned CHANNEL_COUNT = 16;
    localparam int unsigned CHANNEL_BITS  = 11;
    localparam int unsigned PAYLOAD_BITS  = PAYLOAD_BYTES * 8;

    localparam logic [7:0] FRAME_LEN_BYTE = 8'd24;
    localparam logic [7:0] FRAME_TYPE     = 8'h16;
    localparam logic [7:0] CRC_POLY       = 8'hD5;
    localparam logic [7:0] ADDR_RESET     = 8'hC8;

    // APB register map
    localparam logic [2:0] REG_SYNC_ADDRESS = 3'd0;

    typedef logic [PAYLOAD_BITS-1:0] payload_t;

    // Status of the frame queue seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    // One byte through the CRC-8, MSB first, no reflection
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in,
                                             input logic [7:0] data);
        logic [7:0] c;
        c = crc_in ^ data;
        for (int b = 0; b < 8; b++)
        begin
            if (c[7])
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/rc_channel_frame_receiver.sv =====
// Top level of the RC channel frame receiver: APB register, front part,
// frame queue and channel emitter. Depends on rcfr_pkg and the rcfr_* modules.
//
// Takes one serial byte per transfer into a 26-byte window. A byte that does
// not fill the window is taken without a wait. The byte that fills it starts a
// check: the byte-serial CRC-8 unit walks the rotating window once round,
// then a decision state either queues the frame payload or drops the oldest
// byte, so the next byte is taken only after ST_CRC and ST_DECIDE, later when
// a good frame finds the queue full and the decision state waits for a free
// entry. While the sync is lost every byte triggers such a check. A valid
// frame gives sixteen channel transfers, one per cycle when the output is not
// stalled; a two-frame queue lets the front keep taking bytes while channels
// drain. sync_address sits at APB address 0 (reset 0xC8).
`default_nettype none

module rc_channel_frame_receiver
    import rcfr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // APB configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // byte input
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  rx_byte,
    // channel output
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [3:0]       channel_index,
    output logic [10:0]      channel_value,
    output logic             last_channel
);

    logic [7:0] sync_reg;
    logic       push;
    logic       pop;
    payload_t   push_data;
    payload_t   pop_data;
    fifo_stat_t fifo_stat;

    // Register access
    assign pready = 1'b1;
    assign prdata = (paddr == REG_SYNC_ADDRESS) ? {24'd0, sync_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sync_reg <= ADDR_RESET;
        else if (psel && penable && pwrite && (paddr[2] == REG_SYNC_ADDRESS[2]))
            sync_reg <= pwdata[7:0];
    end

    rcfr_frame_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .sync_address (sync_reg),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .rx_byte      (rx_byte),
        .fifo_stat    (fifo_stat),
        .push         (push),
        .push_data    (push_data)
    );

    rcfr_payload_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .stat      (fifo_stat)
    );

    rcfr_channel_emitter u_emitter (
        .clk           (clk),
        .rst_n         (rst_n),
        .fifo_stat     (fifo_stat),
        .pop_data      (pop_data),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .channel_index (channel_index),
        .channel_value (channel_value),
        .last_channel  (last_channel)
    );

endmodule

`default_nettype wire

// ===== rtl/rcfr_frame_front.sv =====
// Front part: byte window with fill count, serial CRC check and frame decision.
// Pushes the 22 payload bytes of each valid frame into the frame queue.
// Depends on rcfr_pkg.
`default_nettype none

module rcfr_frame_front
    import rcfr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [7:0] sync_address,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] rx_byte,
    input  wire fifo_stat_t fifo_stat,
    output logic            push,
    output payload_t        push_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CRC,
        ST_DECIDE
    } state_t;

    state_t     state_reg, state_next;
    logic [4:0] fill_reg, fill_next;
    logic [4:0] cnt_reg, cnt_next;
    logic [7:0] crc_reg, crc_next;
    logic [7:0] win_reg [FRAME_BYTES];
    logic [7:0] win_next [FRAME_BYTES];
    logic       frame_ok;

    // Header and CRC compare against the restored window
    assign frame_ok = (win_reg[0] == sync_address) && (win_reg[1] == FRAME_LEN_BYTE) &&
                      (win_reg[2] == FRAME_TYPE) && (crc_reg == win_reg[FRAME_BYTES-1]);

    // Payload bytes, LSB of the first payload byte at bit 0
    always_comb
    begin
        for (int i = 0; i < PAYLOAD_BYTES; i++)
            push_data[8*i +: 8] = win_reg[HDR_BYTES + i];
    end

    assign in_ready = (state_reg == ST_IDLE);

    // Next-state logic
    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        cnt_next   = cnt_reg;
        crc_next   = crc_reg;
        win_next   = win_reg;
        push       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && (fill_reg < 5'(FRAME_BYTES)))
                begin
                    win_next[fill_reg] = rx_byte;
                    fill_next = fill_reg + 5'd1;
                    if (fill_reg == 5'(FRAME_BYTES - 1))
                    begin
                        state_next = ST_CRC;
                        cnt_next   = 5'd0;
                        crc_next   = 8'd0;
                    end
                end
            end
            ST_CRC:
            begin
                // rotate the whole window once round, feeding the oldest byte
                for (int i = 0; i < FRAME_BYTES - 1; i++)
                    win_next[i] = win_reg[i+1];
                win_next[FRAME_BYTES-1] = win_reg[0];
                if (cnt_reg < 5'(CRC_BYTES))
                    crc_next = crc8_byte(crc_reg, win_reg[0]);
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'(FRAME_BYTES - 1))
                    state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (frame_ok)
                begin
                    if (!fifo_stat.full)
                    begin
                        push       = 1'b1;
                        fill_next  = 5'd0;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    // drop the oldest byte
                    for (int i = 0; i < FRAME_BYTES - 1; i++)
                        win_next[i] = win_reg[i+1];
                    fill_next  = 5'(FRAME_BYTES - 1);
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fill_reg  <= 5'd0;
            cnt_reg   <= 5'd0;
            crc_reg   <= 8'd0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            cnt_reg   <= cnt_next;
            crc_reg   <= crc_next;
        end
    end

    // Byte window
    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
    end

endmodule

`default_nettype wire

// ===== rtl/rcfr_payload_fifo.sv =====
// Two-entry queue of frame payloads between the front and back parts.
// Depends on rcfr_pkg.
`default_nettype none

module rcfr_payload_fifo
    import rcfr_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire payload_t push_data,
    input  wire logic     pop,
    output payload_t      pop_data,
    output fifo_stat_t    stat
);

    payload_t   mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign stat.full  = (count_reg == 2'd2);
    assign stat.empty = (count_reg == 2'd0);
    assign pop_data   = mem_reg[rd_ptr_reg];

    // Pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = ~wr_ptr_reg;
            count_next  = count_next + 2'd1;
        end
        if (pop)
        begin
            rd_ptr_next = ~rd_ptr_reg;
            count_next  = count_next - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire

// ===== rtl/rcfr_channel_emitter.sv =====
// Back part: unpacks one queued payload into sixteen 11-bit channel transfers
// through an output register. Depends on rcfr_pkg.
`default_nettype none

module rcfr_channel_emitter
    import rcfr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire fifo_stat_t  fifo_stat,
    input  wire payload_t    pop_data,
    output logic             pop,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [3:0]       channel_index,
    output logic [10:0]      channel_value,
    output logic             last_channel
);

    logic       active_reg, active_next;
    logic [3:0] cnt_reg, cnt_next;
    payload_t   sh_reg, sh_next;
    logic       valid_reg, valid_next;
    logic [3:0] index_reg, index_next;
    logic [10:0] value_reg, value_next;
    logic       last_reg, last_next;

    assign pop           = !active_reg && !fifo_stat.empty;
    assign out_valid     = valid_reg;
    assign channel_index = index_reg;
    assign channel_value = value_reg;
    assign last_channel  = last_reg;

    // Load a frame, then shift one channel out per free output slot
    always_comb
    begin
        active_next = active_reg;
        cnt_next    = cnt_reg;
        sh_next     = sh_reg;
        valid_next  = valid_reg;
        index_next  = index_reg;
        value_next  = value_reg;
        last_next   = last_reg;
        if (valid_reg && out_ready)
            valid_next = 1'b0;
        if (pop)
        begin
            active_next = 1'b1;
            cnt_next    = 4'd0;
            sh_next     = pop_data;
        end
        else if (active_reg && (!valid_reg || out_ready))
        begin
            valid_next = 1'b1;
            index_next = cnt_reg;
            value_next = sh_reg[CHANNEL_BITS-1:0];
            last_next  = (cnt_reg == 4'(CHANNEL_COUNT - 1));
            sh_next    = sh_reg >> CHANNEL_BITS;
            cnt_next   = cnt_reg + 4'd1;
            if (cnt_reg == 4'(CHANNEL_COUNT - 1))
                active_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            cnt_reg    <= 4'd0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            cnt_reg    <= cnt_next;
            valid_reg  <= valid_next;
        end
    end

    // Payload path
    always_ff @(posedge clk)
    begin
        sh_reg    <= sh_next;
        index_reg <= index_next;
        value_reg <= value_next;
        last_reg  <= last_next;
    end

endmodule

`default_nettype wire
